FILE: rtl/core/pidsc_pkg.sv
// Shared widths, codes and request types of the PID speed controller.
package pidsc_pkg;

    localparam int GAIN_W  = 32;
    localparam int SPEED_W = 16;
    localparam int DT_W    = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int LIMIT_W = 15;
    localparam int ACC_W   = 48;
    localparam int DRIVE_W = 16;
    localparam int TERM_W  = 32;
    localparam int FRAC_W  = 16;

    // Shift-add multiplier: one multiplier bit per cycle.
    localparam int MCAND_W = 48;
    localparam int MPLR_W  = 17;
    localparam int PROD_W  = MCAND_W + MPLR_W;

    // Restoring divider: one quotient bit per cycle.
    localparam int DVD_W = 48;
    localparam int DVS_W = 16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;

    typedef enum logic [1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2,
        REG_LIMIT  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PH1_GO,
        S_PH1_WAIT,
        S_PH2_GO,
        S_PH2_WAIT,
        S_ACC,
        S_RAW1,
        S_RAW2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [MCAND_W-1:0] mcand;
        logic [MPLR_W-1:0]  mplr;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

endpackage

FILE: rtl/core/pidsc_in_if.sv
// Input request channel of the PID speed controller.
interface pidsc_in_if import pidsc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [SPEED_W-1:0] target_speed;
    logic        [DT_W-1:0]    elapsed_ms;

    modport source (output valid, measured_speed, target_speed, elapsed_ms, input ready);
    modport sink (input valid, measured_speed, target_speed, elapsed_ms, output ready);
endinterface

FILE: rtl/core/pidsc_out_if.sv
// Result channel of the PID speed controller.
interface pidsc_out_if import pidsc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_out;
    logic signed [TERM_W-1:0]  term_p;
    logic signed [TERM_W-1:0]  term_i;
    logic signed [TERM_W-1:0]  term_d;
    logic signed [ERR_W-1:0]   speed_error;

    modport source (output valid, drive_out, term_p, term_i, term_d, speed_error,
                    input ready);
    modport sink (input valid, drive_out, term_p, term_i, term_d, speed_error,
                  output ready);
endinterface

FILE: rtl/core/pid_speed_controller_core.sv
// Top level of the PID speed controller: sequencer, PID arithmetic and register port.
//
// Speed PID with a symmetric drive clamp and anti-windup. Each request carries a
// measured speed, a target speed and the milliseconds since the last update; the
// block answers with one result holding the clamped drive (mA, truncated toward
// zero) and the integer parts of the P, I and D terms plus the speed error. Gains
// are signed Q16.16 and the integral is held as a saturating Q32.16 value. D is
// gain_d * (error - previous error) / elapsed_ms and is zero when elapsed_ms is
// zero. One request is worked at a time, and the next request is taken the
// cycle after the result is registered. The time a request takes is set by the
// 17-step shift-add multiply that forms the derivative product followed by the
// 48-step restoring divide by elapsed_ms; the P and I products run on two
// multipliers alongside. A finished result waits in the output register while
// the next request is already being accepted. Registers sit on an APB-style port
// at byte addresses 0 (gain_p), 4 (gain_i), 8 (gain_d) and 12 (output_limit,
// reset 16384); write them only while no request is in flight.
module pid_speed_controller_core import pidsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pidsc_in_if.sink           i_req,
    pidsc_out_if.source        o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int PROP_W = ACC_W + 1;   // signed P, magnitude below 2^47
    localparam int DER_W  = DVD_W + 1;   // signed D, magnitude below 2^48
    localparam int PD_W   = DER_W + 1;
    localparam int RAW_W  = PD_W + 1;

    localparam logic signed [PROD_W-1:0] ACC_HI =
        {{(PROD_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [PROD_W-1:0] ACC_LO = ~ACC_HI;
    localparam logic [TERM_W-1:0] TERM_POS = {1'b0, {(TERM_W - 1){1'b1}}};
    localparam logic [TERM_W-1:0] TERM_NEG = {1'b1, {(TERM_W - 1){1'b0}}};

    function automatic logic [GAIN_W-1:0] f_mag_gain(input logic signed [GAIN_W-1:0] v);
        return v[GAIN_W-1] ? GAIN_W'(-v) : GAIN_W'(v);
    endfunction

    // Saturate a sign and magnitude pair to the 32 bit term range.
    function automatic logic [TERM_W-1:0] f_sat_term(input logic neg,
                                                     input logic [TERM_W-1:0] mag);
        if (!neg) begin
            return (mag > TERM_POS) ? TERM_POS : mag;
        end
        return (mag > TERM_NEG) ? TERM_NEG : TERM_W'(-mag);
    endfunction

    // ---------------------------------------------------------------- registers
    logic signed [GAIN_W-1:0]  r_gain_p;
    logic signed [GAIN_W-1:0]  r_gain_i;
    logic signed [GAIN_W-1:0]  r_gain_d;
    logic        [LIMIT_W-1:0] r_limit;

    logic                     cfg_wr;
    t_reg_idx                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_limit  <= LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GAIN_P: r_gain_p <= pwdata;
                REG_GAIN_I: r_gain_i <= pwdata;
                REG_GAIN_D: r_gain_d <= pwdata;
                REG_LIMIT:  r_limit  <= pwdata[LIMIT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GAIN_P: prdata = r_gain_p;
            REG_GAIN_I: prdata = r_gain_i;
            REG_GAIN_D: prdata = r_gain_d;
            REG_LIMIT:  prdata = APB_DW'(r_limit);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- state
    t_state                    r_state;
    t_state                    n_state;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ERR_W-1:0]   r_last_err;
    logic                      r_out_valid;

    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic        [DT_W-1:0]    r_dt;
    logic signed [PROP_W-1:0]  r_prop;
    logic signed [DER_W-1:0]   r_deriv;
    logic signed [PD_W-1:0]    r_pd;
    logic signed [RAW_W-1:0]   r_raw;
    logic        [TERM_W-1:0]  r_tp;
    logic        [TERM_W-1:0]  r_td;
    logic        [TERM_W-1:0]  r_ti;

    logic signed [DRIVE_W-1:0] r_drive;
    logic signed [TERM_W-1:0]  r_term_p;
    logic signed [TERM_W-1:0]  r_term_i;
    logic signed [TERM_W-1:0]  r_term_d;
    logic signed [ERR_W-1:0]   r_speed_err;

    // ---------------------------------------------------------------- units
    t_mul_req          mul_a_req;
    t_mul_req          mul_b_req;
    t_div_req          div_req;
    logic              a_busy;
    logic              b_busy;
    logic              d_busy;
    logic [PROD_W-1:0] a_prod;
    logic [PROD_W-1:0] b_prod;
    logic [DVD_W-1:0]  d_quot;

    // Multiplier A: gain_d*diff, then gain_p*error.
    pidsc_mul u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_a_req),
        .o_busy  (a_busy),
        .o_prod  (a_prod)
    );

    // Multiplier B: gain_i*error, then that product times elapsed_ms.
    pidsc_mul u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_b_req),
        .o_busy  (b_busy),
        .o_prod  (b_prod)
    );

    // Divider: derivative product over elapsed_ms.
    pidsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (d_busy),
        .o_quot  (d_quot)
    );

    // ---------------------------------------------------------------- front end
    logic                      in_acc;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [DIFF_W-1:0]  n_diff;
    logic        [MPLR_W-1:0]  err_mag;
    logic        [MPLR_W-1:0]  diff_mag;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;

    // Error and its change, both exact at their widths.
    assign n_err  = ERR_W'(i_req.target_speed) - ERR_W'(i_req.measured_speed);
    assign n_diff = DIFF_W'(n_err) - DIFF_W'(r_last_err);

    // Work on magnitudes; signs are put back once the products are in.
    assign err_mag  = r_err[ERR_W-1] ? MPLR_W'(-r_err) : MPLR_W'(r_err);
    assign diff_mag = r_diff[DIFF_W-1] ? MPLR_W'(-r_diff) : MPLR_W'(r_diff);

    // ---------------------------------------------------------------- sequencer
    logic load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        load_out  = 1'b0;
        mul_a_req = '0;
        mul_b_req = '0;
        div_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_PH1_GO;
                end
            end
            S_PH1_GO: begin
                mul_a_req.start = 1'b1;
                mul_a_req.mcand = MCAND_W'(f_mag_gain(r_gain_d));
                mul_a_req.mplr  = diff_mag;
                mul_b_req.start = 1'b1;
                mul_b_req.mcand = MCAND_W'(f_mag_gain(r_gain_i));
                mul_b_req.mplr  = err_mag;
                n_state         = S_PH1_WAIT;
            end
            S_PH1_WAIT: begin
                if (!a_busy && !b_busy) begin
                    n_state = S_PH2_GO;
                end
            end
            S_PH2_GO: begin
                // Skip the divide when no time has passed; D is then zero.
                div_req.start    = (r_dt != '0);
                div_req.dividend = a_prod[DVD_W-1:0];
                div_req.divisor  = r_dt;
                mul_a_req.start  = 1'b1;
                mul_a_req.mcand  = MCAND_W'(f_mag_gain(r_gain_p));
                mul_a_req.mplr   = err_mag;
                mul_b_req.start  = 1'b1;
                mul_b_req.mcand  = b_prod[MCAND_W-1:0];
                mul_b_req.mplr   = MPLR_W'(r_dt);
                n_state          = S_PH2_WAIT;
            end
            S_PH2_WAIT: begin
                if (!a_busy && !b_busy && !d_busy) begin
                    n_state = S_ACC;
                end
            end
            S_ACC:  n_state = S_RAW1;
            S_RAW1: n_state = S_RAW2;
            S_RAW2: n_state = S_OUT;
            S_OUT: begin
                // Hold until the output register is free or being emptied.
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- integral
    logic                     p_neg;
    logic                     i_neg;
    logic                     d_neg;
    logic [DVD_W-1:0]         d_mag;
    logic signed [PROD_W-1:0] inc_val;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;

    assign p_neg = r_gain_p[GAIN_W-1] ^ r_err[ERR_W-1];
    assign i_neg = r_gain_i[GAIN_W-1] ^ r_err[ERR_W-1];
    assign d_neg = r_gain_d[GAIN_W-1] ^ r_diff[DIFF_W-1];
    assign d_mag = (r_dt != '0) ? d_quot : '0;

    // The increment magnitude stays below 2^63, so two guard bits are zero.
    assign inc_val = i_neg ? -$signed({2'b00, b_prod[PROD_W-3:0]})
                           :  $signed({2'b00, b_prod[PROD_W-3:0]});
    assign acc_sum = PROD_W'(r_acc) + inc_val;

    always_comb begin
        if (acc_sum > ACC_HI) begin
            acc_sat = ACC_HI[ACC_W-1:0];
        end else if (acc_sum < ACC_LO) begin
            acc_sat = ACC_LO[ACC_W-1:0];
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // ---------------------------------------------------------------- clamp
    logic [ACC_W-1:0]         acc_bias;
    logic [RAW_W-1:0]         raw_bias;
    logic signed [RAW_W-1:0]  bound;
    logic                     clip_hi;
    logic                     clip_lo;
    logic                     windup;
    logic signed [DRIVE_W-1:0] n_drive;

    // Bias negative values by one less than 2^16 so the shift truncates toward zero.
    assign acc_bias = ACC_W'(r_acc) +
        (r_acc[ACC_W-1] ? {{(ACC_W - FRAC_W){1'b0}}, {FRAC_W{1'b1}}} : '0);
    assign raw_bias = RAW_W'(r_raw) +
        (r_raw[RAW_W-1] ? {{(RAW_W - FRAC_W){1'b0}}, {FRAC_W{1'b1}}} : '0);

    assign bound   = RAW_W'({r_limit, {FRAC_W{1'b0}}});
    assign clip_hi = (r_raw > bound);
    assign clip_lo = (r_raw < -bound);

    // Clear the integral when the clamp acted and the drive pushes along the error.
    assign windup = (clip_hi || clip_lo) &&
                    ((r_raw > 0 && r_err > 0) || (r_raw < 0 && r_err < 0));

    always_comb begin
        if (clip_hi) begin
            n_drive = $signed({1'b0, r_limit});
        end else if (clip_lo) begin
            n_drive = -$signed({1'b0, r_limit});
        end else begin
            n_drive = raw_bias[FRAC_W+DRIVE_W-1:FRAC_W];
        end
    end

    // ---------------------------------------------------------------- state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_ACC) begin
                r_acc <= acc_sat;
            end
            if (load_out) begin
                r_acc       <= windup ? '0 : r_acc;
                r_last_err  <= r_err;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err  <= n_err;
            r_diff <= n_diff;
            r_dt   <= i_req.elapsed_ms;
        end
        if (r_state == S_ACC) begin
            r_prop  <= p_neg ? -$signed({1'b0, a_prod[ACC_W-1:0]})
                             :  $signed({1'b0, a_prod[ACC_W-1:0]});
            r_deriv <= d_neg ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});
            r_tp    <= f_sat_term(p_neg, a_prod[FRAC_W+TERM_W-1:FRAC_W]);
            r_td    <= f_sat_term(d_neg, d_mag[FRAC_W+TERM_W-1:FRAC_W]);
        end
        if (r_state == S_RAW1) begin
            r_pd <= PD_W'(r_prop) + PD_W'(r_deriv);
        end
        if (r_state == S_RAW2) begin
            r_raw <= RAW_W'(r_pd) + RAW_W'(r_acc);
            r_ti  <= acc_bias[ACC_W-1:FRAC_W];
        end
        if (load_out) begin
            r_drive     <= n_drive;
            r_term_p    <= r_tp;
            r_term_i    <= windup ? '0 : r_ti;
            r_term_d    <= r_td;
            r_speed_err <= r_err;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.drive_out   = r_drive;
    assign o_res.term_p      = r_term_p;
    assign o_res.term_i      = r_term_i;
    assign o_res.term_d      = r_term_d;
    assign o_res.speed_error = r_speed_err;

endmodule

FILE: rtl/core/pidsc_mul.sv
// Radix-2 shift-add multiplier for unsigned magnitudes.
module pidsc_mul import pidsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output logic              o_busy,
    output logic [PROD_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MPLR_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_mc;
    logic [PROD_W-1:0] r_acc;
    logic [MPLR_W-1:0] r_mp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MPLR_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // One multiplier bit per cycle, least significant first.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mc  <= PROD_W'(i_req.mcand);
            r_mp  <= i_req.mplr;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule

FILE: rtl/core/pidsc_div.sv
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
module pidsc_div import pidsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   trial;

    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!trial[DVS_W]) begin
                r_rem <= trial[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DVS_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/pidsc_checker.sv
// Port-level assertions for the PID speed controller, bound to its top level.
module pidsc_checker import pidsc_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [DRIVE_W-1:0] i_drive_out,
    input logic signed [ERR_W-1:0]   i_speed_error
);

    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W - 1){1'b0}}};

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_drive_out) && $stable(i_speed_error))
        else $error("stalled result changed");

    // One request in flight: input closes right after an accept.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while busy");

    // A fresh result reopens the input in the same cycle.
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $rose(i_in_ready))
        else $error("result appeared without freeing the input");

    // The clamp is symmetric, so the most negative code never shows.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_drive_out != DRIVE_MIN)
        else $error("drive outside the symmetric range");

endmodule

bind pid_speed_controller_core pidsc_checker u_pidsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_drive_out   (o_res.drive_out),
    .i_speed_error (o_res.speed_error)
);
